@@ sv/uart_rx_idle_gap_packet_buffer_assert.svh @@
// Assertion macros for the idle-gap receive buffer checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef UART_RX_IDLE_GAP_PACKET_BUFFER_ASSERT_SVH
`define UART_RX_IDLE_GAP_PACKET_BUFFER_ASSERT_SVH

// checked only out of reset
`define URX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define URX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/urx_gap_pkg.sv @@
// Shared types and constants for the idle-gap receive buffer.
// No dependencies.
package urx_gap_pkg;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_POLL  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [7:0] GAP_LIMIT_RST = 8'd3;

	// result fields carried from the accept stage to the output register
	typedef struct packed {
		logic [7:0] packet_len;
		logic [7:0] byte_total;
		logic       overflow;
		logic       rd_ok;
	} res_t;

endpackage

@@ sv/urx_gap_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while re is low. No dependencies.
module urx_gap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/uart_rx_idle_gap_packet_buffer.sv @@
// Idle-gap receive buffer: one item per clock cycle while m_tready does not
// stall the output. Counters update at acceptance; each result then passes
// through the buffer RAM's registered read and the output register. The buffer
// RAM has no clearing pass after reset: entries are only read below the fill
// count, so all were written. Uses urx_gap_pkg and urx_gap_ram.
module uart_rx_idle_gap_packet_buffer
	import urx_gap_pkg::*;
#(
	parameter int BUFFER_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,     // gap_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // [7:0] rx_byte, [14:8] read_index
	input  logic [1:0]  s_tuser,       // cmd
	input  logic        s_tlast,       // release_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,       // [7:0] packet_len, [15:8] read_data, [23:16] byte_total
	output logic        m_tuser        // overflow
);

	localparam int CW   = $clog2(BUFFER_DEPTH + 1);
	localparam int AW   = $clog2(BUFFER_DEPTH);
	localparam int CMPW = (CW > 7 ? CW : 7) + 1;

	logic [CW-1:0] cnt_q, cnt_d, seen_q, seen_d;
	logic [7:0]    gap_q, gap_d, gap_inc, limit_q;
	logic          v_s1, v_out_q;
	res_t          res_d, res_s1;
	logic          acc, out_free, s1_move, wr, full;
	cmd_t          cmd;
	logic [6:0]    idx;
	logic [7:0]    ram_rdata;
	logic [23:0]   tdata_q;
	logic          tuser_q;

	assign cmd      = cmd_t'(s_tuser);
	assign idx      = s_tdata[14:8];
	assign out_free = !v_out_q || m_tready;
	assign s1_move  = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;
	assign acc      = s_tvalid && s_tready;
	assign full     = (cnt_q == CW'(BUFFER_DEPTH));
	assign gap_inc  = gap_q + 8'd1;

	always_comb begin
		cnt_d  = cnt_q;
		gap_d  = gap_q;
		seen_d = seen_q;
		wr     = 1'b0;
		res_d.packet_len = '0;
		res_d.overflow   = 1'b0;
		res_d.rd_ok = ({{(CMPW-7){1'b0}}, idx} < CMPW'(cnt_q))
			&& (32'(idx) < 32'(BUFFER_DEPTH));
		if (acc) begin
			unique case (cmd)
				CMD_BYTE: begin
					if (!full) begin
						wr    = 1'b1;
						cnt_d = CW'(cnt_q + 1'b1);
					end else begin
						res_d.overflow = 1'b1;
					end
				end
				CMD_POLL: begin
					if (cnt_q != '0) begin
						gap_d = gap_inc;
						if (gap_inc > limit_q) begin
							gap_d = '0;
							if (seen_q != cnt_q) begin
								seen_d = cnt_q;
							end else begin
								seen_d = '0;
								res_d.packet_len = 8'(cnt_q);
							end
						end
					end
				end
				CMD_READ: begin
					if (s_tlast) begin
						cnt_d = '0;
					end
				end
				CMD_CLEAR: begin
					cnt_d = '0;
				end
			endcase
		end
		if (cmd != CMD_READ) begin
			res_d.rd_ok = 1'b0;
		end
		res_d.byte_total = 8'(cnt_d);
	end

	// Writes land only at the fill count and reads only below it, and a write
	// completes before any later item's read, so no forwarding is needed.
	urx_gap_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (AW'(cnt_q)),
		.wdata (s_tdata[7:0]),
		.re    (acc),
		.raddr (AW'(idx)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			gap_q   <= '0;
			seen_q  <= '0;
			limit_q <= GAP_LIMIT_RST;
			v_s1    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			gap_q  <= gap_d;
			seen_q <= seen_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				v_out_q <= 1'b1;
			end else if (m_tready) begin
				v_out_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_d;
		end
		if (s1_move) begin
			tdata_q <= {res_s1.byte_total, (res_s1.rd_ok ? ram_rdata : 8'd0),
				res_s1.packet_len};
			tuser_q <= res_s1.overflow;
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

endmodule

@@ sv/urx_gap_chk.sv @@
// Port-level checker for uart_rx_idle_gap_packet_buffer, bound to the top level.
// Uses the macros in uart_rx_idle_gap_packet_buffer_assert.svh.
`include "uart_rx_idle_gap_packet_buffer_assert.svh"

module urx_gap_chk #(
	parameter int BUFFER_DEPTH = 128
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [7:0]  cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	`URX_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !m_tvalid, "result valid in reset")

	`URX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// a poll and a read never share one item
	`URX_ASSERT(a_len_or_data, m_tvalid |-> m_tdata[7:0] == 8'd0 || m_tdata[15:8] == 8'd0, "packet_len and read_data both set")

	// a dropped byte means a full buffer and nothing else reported
	`URX_ASSERT(a_ovf_full, m_tvalid && m_tuser |-> m_tdata[23:16] == 8'(BUFFER_DEPTH) && m_tdata[15:0] == 16'd0, "overflow without full buffer")

	`URX_ASSERT(a_total_range, m_tvalid |-> 32'(m_tdata[23:16]) <= BUFFER_DEPTH || BUFFER_DEPTH > 255, "byte_total beyond depth")

endmodule

bind uart_rx_idle_gap_packet_buffer urx_gap_chk #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_chk (.*);
